/* rtl/wsd_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package wsd_pkg;

    localparam int DATA_W = 8;
    localparam int LEN_W  = 63;

    localparam logic [6:0] LEN_CODE_16  = 7'd126;
    localparam logic [6:0] LEN_CODE_64  = 7'd127;
    localparam logic [3:0] CLOSE_OPCODE = 4'd8;

    typedef struct packed {
        logic [DATA_W-1:0] payload_byte;
        logic              payload_valid;
        logic              fin_bit;
        logic [2:0]        reserved_bits;
        logic [3:0]        frame_opcode;
        logic              masked_flag;
        logic [LEN_W-1:0]  payload_length;
        logic              close_request;
        logic              result_last;
        logic              header_error;
    } t_result;

endpackage

`default_nettype wire

/* rtl/wsd_in_if.sv */
// Input channel of the deframer: one raw message byte per transaction.
// Depends on wsd_pkg for the byte width.
`default_nettype none

interface wsd_in_if
    import wsd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              message_end;

    modport source (output valid, output data_byte, output message_end, input ready);
    modport sink   (input valid, input data_byte, input message_end, output ready);
endinterface

`default_nettype wire

/* rtl/wsd_out_if.sv */
// Result channel of the deframer: one decoded payload byte or report per transaction.
// Depends on wsd_pkg for the field widths.
`default_nettype none

interface wsd_out_if
    import wsd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] payload_byte;
    logic              payload_valid;
    logic              fin_bit;
    logic [2:0]        reserved_bits;
    logic [3:0]        frame_opcode;
    logic              masked_flag;
    logic [LEN_W-1:0]  payload_length;
    logic              close_request;
    logic              result_last;
    logic              header_error;

    modport source (
        output valid, output payload_byte, output payload_valid, output fin_bit,
        output reserved_bits, output frame_opcode, output masked_flag,
        output payload_length, output close_request, output result_last,
        output header_error, input ready
    );
    modport sink (
        input valid, input payload_byte, input payload_valid, input fin_bit,
        input reserved_bits, input frame_opcode, input masked_flag,
        input payload_length, input close_request, input result_last,
        input header_error, output ready
    );
endinterface

`default_nettype wire

/* rtl/websocket_frame_deframer.sv */
// Top level of the WebSocket frame deframer: input register, parser and result register.
// Depends on wsd_pkg, wsd_in_if, wsd_out_if and wsd_parser.
//
// The block takes one byte of a received message per cycle while no result is stalled, and
// returns at most one result per byte. A taken byte waits in the input register, then the
// parser decodes the header or unmasks the byte in a single pass into the result register,
// from which the result is offered. Header bytes give no result unless they carry
// message_end, in which case a header-only report or an error report is returned. A
// stalled result holds in the result register while the next byte can still move into
// an empty input register. The sustained rate is one byte per cycle while results are
// not stalled.
`default_nettype none

module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wsd_in_if.sink     i_data,
    wsd_out_if.source  o_res
);

    logic              r_s1_valid;
    logic [DATA_W-1:0] r_s1_byte;
    logic              r_s1_end;
    logic              r_out_valid;
    t_result           r_out;
    logic              w_out_stall;
    logic              w_step;
    logic              w_emit;
    t_result           w_result;

    assign w_out_stall  = r_out_valid && !o_res.ready;
    assign w_step       = r_s1_valid && !w_out_stall;
    assign i_data.ready = !r_s1_valid || !w_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_data.ready) begin
            r_s1_valid <= i_data.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_data.valid && i_data.ready) begin
            r_s1_byte <= i_data.data_byte;
            r_s1_end  <= i_data.message_end;
        end
    end

    wsd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_data_byte   (r_s1_byte),
        .i_message_end (r_s1_end),
        .o_emit        (w_emit),
        .o_result      (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!w_out_stall) begin
            r_out_valid <= w_step && w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.payload_byte   = r_out.payload_byte;
    assign o_res.payload_valid  = r_out.payload_valid;
    assign o_res.fin_bit        = r_out.fin_bit;
    assign o_res.reserved_bits  = r_out.reserved_bits;
    assign o_res.frame_opcode   = r_out.frame_opcode;
    assign o_res.masked_flag    = r_out.masked_flag;
    assign o_res.payload_length = r_out.payload_length;
    assign o_res.close_request  = r_out.close_request;
    assign o_res.result_last    = r_out.result_last;
    assign o_res.header_error   = r_out.header_error;

endmodule

`default_nettype wire

/* rtl/wsd_parser.sv */
// Frame header parser, mask key capture and payload unmask for the deframer.
// Holds the parse state; depends on wsd_pkg for the result type and length codes.
`default_nettype none

module wsd_parser
    import wsd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [DATA_W-1:0] i_data_byte,
    input  wire logic              i_message_end,
    output logic                   o_emit,
    output t_result                o_result
);

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SECOND,
        PH_EXT16,
        PH_EXT64,
        PH_KEY,
        PH_PAYLOAD
    } t_phase;

    t_phase      r_phase, n_phase, w_phase_pre;
    logic [2:0]  r_count, n_count;
    logic [63:0] r_length, n_length;
    logic [31:0] r_key, n_key;
    logic [1:0]  r_mask_pos, n_mask_pos;
    logic [8:0]  r_header, n_header;
    logic [7:0]  w_key_byte;
    logic        w_in_payload;

    always_comb begin
        case (r_mask_pos)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        w_phase_pre = r_phase;
        n_count     = r_count;
        n_length    = r_length;
        n_key       = r_key;
        n_mask_pos  = r_mask_pos;
        n_header    = r_header;
        case (r_phase)
            PH_PAYLOAD: begin
                n_mask_pos = r_mask_pos + 2'd1;
            end
            PH_SECOND: begin
                n_header = {r_header[8:1], i_data_byte[7]};
                n_count  = 3'd0;
                if (i_data_byte[6:0] == LEN_CODE_16) begin
                    n_length    = 64'd0;
                    w_phase_pre = PH_EXT16;
                end else if (i_data_byte[6:0] == LEN_CODE_64) begin
                    n_length    = 64'd0;
                    w_phase_pre = PH_EXT64;
                end else begin
                    n_length    = {57'd0, i_data_byte[6:0]};
                    w_phase_pre = i_data_byte[7] ? PH_KEY : PH_PAYLOAD;
                end
            end
            PH_EXT16, PH_EXT64: begin
                n_length = {r_length[55:0], i_data_byte};
                if ((r_phase == PH_EXT16 && r_count == 3'd1) || r_count == 3'd7) begin
                    n_count     = 3'd0;
                    w_phase_pre = r_header[0] ? PH_KEY : PH_PAYLOAD;
                end else begin
                    n_count = r_count + 3'd1;
                end
            end
            PH_KEY: begin
                n_key = {r_key[23:0], i_data_byte};
                if (r_count >= 3'd3) begin
                    n_count     = 3'd0;
                    w_phase_pre = PH_PAYLOAD;
                end else begin
                    n_count = r_count + 3'd1;
                end
            end
            default: begin
                n_header    = {i_data_byte[7], i_data_byte[6:4], i_data_byte[3:0], 1'b0};
                n_length    = 64'd0;
                n_key       = 32'd0;
                n_mask_pos  = 2'd0;
                n_count     = 3'd0;
                w_phase_pre = PH_SECOND;
            end
        endcase
        n_phase = w_phase_pre;
        if (i_message_end) begin
            n_phase = PH_FIRST;
            n_count = 3'd0;
        end
    end

    assign w_in_payload = (r_phase == PH_PAYLOAD);

    always_comb begin
        o_emit                  = w_in_payload || i_message_end;
        o_result.payload_byte   = w_in_payload ? (i_data_byte ^ w_key_byte) : '0;
        o_result.payload_valid  = w_in_payload;
        o_result.fin_bit        = n_header[8];
        o_result.reserved_bits  = n_header[7:5];
        o_result.frame_opcode   = n_header[4:1];
        o_result.masked_flag    = n_header[0];
        o_result.payload_length = (w_phase_pre == PH_PAYLOAD) ? n_length[LEN_W-1:0] : '0;
        o_result.close_request  = (n_header[4:1] == CLOSE_OPCODE);
        o_result.result_last    = i_message_end;
        o_result.header_error   = i_message_end && (w_phase_pre != PH_PAYLOAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FIRST;
            r_count    <= 3'd0;
            r_length   <= 64'd0;
            r_key      <= 32'd0;
            r_mask_pos <= 2'd0;
            r_header   <= 9'd0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_count    <= n_count;
            r_length   <= n_length;
            r_key      <= n_key;
            r_mask_pos <= n_mask_pos;
            r_header   <= n_header;
        end
    end

endmodule

`default_nettype wire

/* rtl/wsd_checker.sv */
// Port-level assertions for the WebSocket frame deframer, bound to the top level.
// Depends on wsd_pkg for the close opcode and field widths.
`default_nettype none

module wsd_checker
    import wsd_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [DATA_W-1:0] i_payload_byte,
    input wire logic              i_payload_valid,
    input wire logic [3:0]        i_frame_opcode,
    input wire logic [LEN_W-1:0]  i_payload_length,
    input wire logic              i_close_request,
    input wire logic              i_result_last,
    input wire logic              i_header_error
);

    // A report without payload only comes from the last byte of a message.
    a_report_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_payload_valid |-> i_result_last && i_payload_byte == '0)
        else $error("header-only or error report not flagged last");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_header_error |-> !i_payload_valid && i_payload_length == '0)
        else $error("header error report carries payload or length");

    a_close_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_close_request == (i_frame_opcode == CLOSE_OPCODE))
        else $error("close flag disagrees with opcode");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while result register is empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_payload_byte))
        else $error("stalled result changed");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_data.ready),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_payload_byte   (o_res.payload_byte),
    .i_payload_valid  (o_res.payload_valid),
    .i_frame_opcode   (o_res.frame_opcode),
    .i_payload_length (o_res.payload_length),
    .i_close_request  (o_res.close_request),
    .i_result_last    (o_res.result_last),
    .i_header_error   (o_res.header_error)
);

`default_nettype wire
